// ===== rtl/moving_rms_filter_defines.svh =====
// assertion macros shared by the moving rms filter checker
`ifndef MOVING_RMS_FILTER_DEFINES_SVH
`define MOVING_RMS_FILTER_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define MRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define MRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrf_pkg.sv =====
// shared types and constants of the moving rms filter
`default_nettype none

package mrf_pkg;

    // fixed field widths and default values
    localparam int SAMPLE_BITS    = 16;
    localparam int CFG_W          = 9;
    localparam int CFG_RESET      = 256;
    localparam int WINDOW_MAX_DEF = 256;

    // largest rms value that can appear (magnitude of the most negative sample)
    localparam int RMS_MAX = 2 ** (SAMPLE_BITS - 1);

    // input word operation codes
    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // input word
    typedef struct packed {
        logic                          mode;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rms_value;
        logic                   window_full;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/moving_rms_filter.sv =====
// moving window rms filter: sample ring, running sum of squares, shared divide and root unit
//
// input channel i_in_valid / o_in_ready carries a word with mode and a signed sample.
// a push word stores the sample, updates the sum of squares and yields one output word
// floor(sqrt(floor(sum / count))) with a full flag; a clear word empties the window
// and yields nothing.
// a push runs through squaring the old sample, subtracting that square once the window
// is full, adding the square of the new one, 2*SAMPLE_BITS - 1 + clog2(WINDOW_MAX)
// divide steps, SAMPLE_BITS root steps and the output step; o_in_ready is low until it
// is done. the work is done by one shared add/subtract unit doing a restoring divide,
// one quotient bit a cycle, then a digit-by-digit square root, one root bit a cycle.
// the output word sits in a register: a stalled receiver does not stop the next word
// being accepted, only the hand-over of the following result, which waits in the last
// step until the output register is free.
// i_cfg_we writes the window length (clamped to 1..WINDOW_MAX) and empties the window;
// write it only while the block is idle.
// synchronous reset: window length 256 (or WINDOW_MAX if smaller), window empty,
// no output pending. the sample ring itself is not cleared, its entries are used only
// once written.
`default_nettype none

module moving_rms_filter
    import mrf_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int POS_W  = $clog2(WINDOW_MAX);
    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = 2 * SB - 1 + $clog2(WINDOW_MAX);
    localparam int ALU_W  = SUM_W + 1;
    localparam int RAD_W  = 2 * SB;
    localparam int SREM_W = SB + 2;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int CMP_W  = (CFG_W > WIN_W) ? CFG_W : WIN_W;
    localparam int WL_RST = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX :
                            ((CFG_RESET < 1) ? 1 : CFG_RESET);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OLD  = 7'b0000010,
        S_NEW  = 7'b0000100,
        S_ADD  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic [WIN_W-1:0]    r_wl, n_wl;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [WIN_W-1:0]    r_fill, n_fill;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_out_valid, n_out_valid;

    // datapath registers
    logic [SB-1:0]       r_ring [WINDOW_MAX];
    logic [SB-1:0]       r_ring_q;
    logic [SB-1:0]       r_sample;
    logic                r_was_full;
    logic [2*SB-1:0]     r_prod;
    logic [SUM_W-1:0]    r_quo;
    logic [WIN_W-1:0]    r_rem;
    logic [RAD_W-1:0]    r_rad;
    logic [SREM_W-1:0]   r_srem;
    logic [SB-1:0]       r_root;
    logic [CNT_W-1:0]    r_cnt;
    t_out_word           r_out_data;

    // combinational signals
    logic                in_acc;
    logic                out_free;
    logic                last_step;
    logic                ring_we;
    logic                ring_re;
    logic [SB-1:0]       sq_src;
    logic [SB-1:0]       sq_mag;
    logic [2*SB-1:0]     sq_prod;
    logic [WIN_W:0]      div_sh;
    logic [SREM_W+1:0]   sqrt_sh;
    logic [SB+1:0]       sqrt_trial;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic                alu_sub;
    logic [ALU_W-1:0]    alu_res;
    logic                alu_ge;
    logic [CMP_W-1:0]    cfg_ext;
    logic [WIN_W-1:0]    cfg_wl;
    logic [WIN_W-1:0]    pos_inc;

    // handshake
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign last_step   = (r_cnt == CNT_W'(1));

    // ring port control
    assign ring_re = in_acc & (i_in_data.mode == MODE_PUSH);
    assign ring_we = (r_state == S_OLD);

    // squaring: old sample first, then the new one
    assign sq_src  = (r_state == S_OLD) ? r_ring_q : r_sample;
    assign sq_mag  = sq_src[SB-1] ? (~sq_src + SB'(1)) : sq_src;
    assign sq_prod = sq_mag * sq_mag;

    // divide and root partial remainders
    assign div_sh     = {r_rem, r_quo[SUM_W-1]};
    assign sqrt_sh    = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign sqrt_trial = {r_root, 2'b01};

    // shared add / subtract unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_NEW: begin
                alu_a   = ALU_W'(r_sum);
                alu_b   = ALU_W'(r_prod);
                alu_sub = 1'b1;
            end
            S_ADD: begin
                alu_a   = ALU_W'(r_sum);
                alu_b   = ALU_W'(r_prod);
                alu_sub = 1'b0;
            end
            S_DIV: begin
                alu_a   = ALU_W'(div_sh);
                alu_b   = ALU_W'(r_fill);
                alu_sub = 1'b1;
            end
            S_SQRT: begin
                alu_a   = ALU_W'(sqrt_sh);
                alu_b   = ALU_W'(sqrt_trial);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_ge  = ~alu_res[ALU_W-1];

    // window length clamp
    assign cfg_ext = CMP_W'(i_cfg_data);
    always_comb begin
        priority if (cfg_ext == '0) begin
            cfg_wl = WIN_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            cfg_wl = WIN_W'(WINDOW_MAX);
        end else begin
            cfg_wl = WIN_W'(cfg_ext);
        end
    end

    // ring position wrap
    assign pos_inc = WIN_W'(r_pos) + WIN_W'(1);

    // sequencer and window state
    always_comb begin
        n_state     = r_state;
        n_wl        = r_wl;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.mode == MODE_CLEAR) begin
                        n_pos  = '0;
                        n_fill = '0;
                        n_sum  = '0;
                    end else begin
                        n_state = S_OLD;
                    end
                end
            end
            S_OLD: begin
                n_state = S_NEW;
            end
            S_NEW: begin
                if (r_was_full) begin
                    n_sum = alu_res[SUM_W-1:0];
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum = alu_res[SUM_W-1:0];
                if (!r_was_full) begin
                    n_fill = r_fill + WIN_W'(1);
                end
                n_pos   = (pos_inc == r_wl) ? '0 : POS_W'(pos_inc);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (last_step) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (last_step) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // register write empties the window
        if (i_cfg_we) begin
            n_wl   = cfg_wl;
            n_pos  = '0;
            n_fill = '0;
            n_sum  = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= WIN_W'(WL_RST);
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wl        <= n_wl;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // sample ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_pos] <= r_sample;
        end
        if (ring_re) begin
            r_ring_q <= r_ring[r_pos];
        end
    end

    // datapath: squares, divide and root iterations, output word
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sample   <= i_in_data.sample;
                    r_was_full <= (r_fill >= r_wl);
                end
            end
            S_OLD: begin
                r_prod <= sq_prod;
            end
            S_NEW: begin
                r_prod <= sq_prod;
            end
            S_ADD: begin
                r_quo <= alu_res[SUM_W-1:0];
                r_rem <= '0;
                r_cnt <= CNT_W'(SUM_W);
            end
            S_DIV: begin
                r_rem <= alu_ge ? alu_res[WIN_W-1:0] : div_sh[WIN_W-1:0];
                r_quo <= {r_quo[SUM_W-2:0], alu_ge};
                if (last_step) begin
                    r_rad  <= {r_quo[RAD_W-2:0], alu_ge};
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= CNT_W'(SB);
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            S_SQRT: begin
                if (alu_ge) begin
                    r_srem <= alu_res[SREM_W-1:0];
                end else begin
                    r_srem <= sqrt_sh[SREM_W-1:0];
                end
                r_root <= {r_root[SB-2:0], alu_ge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - CNT_W'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data.rms_value   <= r_root;
                    r_out_data.window_full <= (r_fill == r_wl);
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mrf_checker.sv =====
// port checker for the moving rms filter, bound to the top level
`default_nettype none
`include "moving_rms_filter_defines.svh"

module mrf_checker
    import mrf_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cfg_we,
    input wire logic [CFG_W-1:0] i_cfg_data,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_word         i_in_data,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_word        o_out_data
);

    logic push_acc;
    logic clear_acc;
    logic cfg_seen;

    // accepted words by kind
    assign push_acc  = i_in_valid & o_in_ready & (i_in_data.mode == MODE_PUSH);
    assign clear_acc = i_in_valid & o_in_ready & (i_in_data.mode == MODE_CLEAR);
    assign cfg_seen  = i_cfg_we;

    // output word is held while the receiver stalls
    `MRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output word dropped while stalled")
    `MRF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data), "output word changed while stalled")

    // a push keeps the block busy in the following cycle
    `MRF_ASSERT_NEXT(a_push_busy, i_clk, i_rst_n, push_acc, !o_in_ready, "ready again right after a push")

    // a clear produces no output word
    `MRF_ASSERT_NEXT(a_clear_silent, i_clk, i_rst_n, clear_acc && !cfg_seen, !$rose(o_out_valid), "clear word produced a result")

    // root of a mean of squares cannot exceed the largest sample magnitude
    `MRF_ASSERT_NOW(a_rms_range, i_clk, i_rst_n, o_out_valid, o_out_data.rms_value <= RMS_MAX, "rms value out of range")

endmodule

bind moving_rms_filter mrf_checker u_mrf_checker (.*);

`default_nettype wire
